FILE: sv/stable_min_priority_queue_macros.svh
// assertion helpers for the priority queue
`ifndef STABLE_MIN_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_MIN_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication, checked out of reset
`define SMPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SMPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/smpq_pkg.sv
package smpq_pkg;

  localparam int OCC_W = 5;

  // operation codes on in_func
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  typedef logic signed [31:0] value_t;
  typedef logic signed [15:0] prio_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [15:0] prio;
  } entry_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic cap;        // capture the incoming pair, walk index to the tail
    logic rd_head;    // read the head slot
    logic rd_prev;    // read the slot in front of the walk index
    logic shift_wr;   // move the read entry one slot back, step index
    logic ins_wr;     // write the new pair at the walk index
    logic pop;        // retire the head entry
    logic res_under;  // report an empty remove
    logic res_over;   // report a dropped insert
  } ctrl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic empty;
    logic full;
    logic idx_zero;
    logic greater;    // read entry is less urgent than the new pair
  } ctrl_sts_t;

endpackage

FILE: sv/smpq_ctrl.sv
module smpq_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  in_func,
  input  smpq_pkg::ctrl_sts_t   sts,
  output smpq_pkg::ctrl_cmd_t   cmd,
  output logic                  busy
);
  import smpq_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_POP     = 4'b0010,
    ST_SEARCH  = 4'b0100,
    ST_COMPARE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_func == FUNC_INSERT) begin
            if (sts.full) begin
              cmd.res_over = 1'b1;
            end else begin
              cmd.cap   = 1'b1;
              state_nxt = ST_SEARCH;
            end
          end else begin
            if (sts.empty) begin
              cmd.res_under = 1'b1;
            end else begin
              cmd.rd_head = 1'b1;
              state_nxt   = ST_POP;
            end
          end
        end
      end
      ST_POP: begin
        cmd.pop   = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_SEARCH: begin
        if (sts.idx_zero) begin
          cmd.ins_wr = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          cmd.rd_prev = 1'b1;
          state_nxt   = ST_COMPARE;
        end
      end
      ST_COMPARE: begin
        if (sts.greater) begin
          cmd.shift_wr = 1'b1;
          state_nxt    = ST_SEARCH;
        end else begin
          cmd.ins_wr = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

FILE: sv/smpq_dp.sv
module smpq_dp #(
  parameter int DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  smpq_pkg::ctrl_cmd_t          cmd,
  output smpq_pkg::ctrl_sts_t          sts,
  input  smpq_pkg::value_t             in_item_value,
  input  smpq_pkg::prio_t              in_item_priority,
  output logic                         out_valid,
  output smpq_pkg::value_t             out_removed_value,
  output smpq_pkg::prio_t              out_removed_priority,
  output logic                         out_underflow,
  output logic                         out_overflow,
  output logic [smpq_pkg::OCC_W-1:0]   out_occupancy
);
  import smpq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // circular store, head_r marks the most urgent entry
  entry_t         mem [DEPTH];
  entry_t         rd_data_r;
  entry_t         new_r;
  logic [AW-1:0]  head_r, head_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [AW-1:0]  idx_r;
  logic [AW-1:0]  idx_m1;
  logic [AW:0]    sum_wr, sum_rd;
  logic [AW-1:0]  wr_addr, rd_addr;

  logic           out_valid_r;
  value_t         res_value_r;
  prio_t          res_prio_r;
  logic           res_under_r, res_over_r;
  logic [OCC_W-1:0] res_occ_r;

  // logical slot to physical address, one compare and subtract
  always_comb begin
    idx_m1 = idx_r - 1'b1;
    sum_wr = {1'b0, head_r} + {1'b0, idx_r};
    sum_rd = {1'b0, head_r} + {1'b0, idx_m1};
    wr_addr = (sum_wr >= (AW+1)'(DEPTH)) ? AW'(sum_wr - (AW+1)'(DEPTH)) : AW'(sum_wr);
    rd_addr = (sum_rd >= (AW+1)'(DEPTH)) ? AW'(sum_rd - (AW+1)'(DEPTH)) : AW'(sum_rd);
    if (cmd.rd_head) begin
      rd_addr = head_r;
    end
  end

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (cmd.pop) begin
      head_nxt  = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end else if (cmd.ins_wr) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_comb begin
    sts.empty    = (count_r == '0);
    sts.full     = (count_r == CW'(DEPTH));
    sts.idx_zero = (idx_r == '0);
    sts.greater  = (rd_data_r.prio > new_r.prio);
  end

  // store write and registered read
  always_ff @(posedge clk) begin
    if (cmd.shift_wr) begin
      mem[wr_addr] <= rd_data_r;
    end else if (cmd.ins_wr) begin
      mem[wr_addr] <= new_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_head || cmd.rd_prev) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= cmd.pop | cmd.ins_wr | cmd.res_under | cmd.res_over;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      idx_r <= AW'(count_r);
      new_r <= '{value: in_item_value, prio: in_item_priority};
    end else if (cmd.shift_wr) begin
      idx_r <= idx_m1;
    end
    res_value_r <= cmd.pop ? rd_data_r.value : '0;
    res_prio_r  <= cmd.pop ? rd_data_r.prio : '0;
    res_under_r <= cmd.res_under;
    res_over_r  <= cmd.res_over;
    res_occ_r   <= OCC_W'(count_nxt);
  end

  assign out_valid            = out_valid_r;
  assign out_removed_value    = res_value_r;
  assign out_removed_priority = res_prio_r;
  assign out_underflow        = res_under_r;
  assign out_overflow         = res_over_r;
  assign out_occupancy        = res_occ_r;

endmodule

FILE: sv/stable_min_priority_queue.sv
// a remove reads the head slot, then retires it; an empty remove or full insert is answered from idle;
//   an insert captures the pair, then walks back from the tail past every less urgent entry
// throughput: one operation at a time, the next start is taken once busy drops;
//   each moved entry costs one read then one write of the store
// results strobe on out_valid for one cycle and cannot be stalled by the receiver
// reset: synchronous active-low rst_n empties the queue; store contents stay undefined
`include "stable_min_priority_queue_macros.svh"

module stable_min_priority_queue #(
  parameter int DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_func,
  input  smpq_pkg::value_t             in_item_value,
  input  smpq_pkg::prio_t              in_item_priority,
  output logic                         out_valid,
  output smpq_pkg::value_t             out_removed_value,
  output smpq_pkg::prio_t              out_removed_priority,
  output logic                         out_underflow,
  output logic                         out_overflow,
  output logic [smpq_pkg::OCC_W-1:0]   out_occupancy
);
  import smpq_pkg::*;

  // command and status between the sequencer and the store datapath
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // sequencer: decides per beat whether to pop, walk the tail, or report a fault
  smpq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_func (in_func),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  // datapath: circular store with head pointer, so a remove needs no shifting;
  // an insert walks back from the tail moving less urgent entries one slot down
  smpq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_item_value        (in_item_value),
    .in_item_priority     (in_item_priority),
    .out_valid            (out_valid),
    .out_removed_value    (out_removed_value),
    .out_removed_priority (out_removed_priority),
    .out_underflow        (out_underflow),
    .out_overflow         (out_overflow),
    .out_occupancy        (out_occupancy)
  );

  // an accepted beat either keeps the block busy or answers right away
  `SMPQ_ASSERT_NEXT(a_accept_progress, start && !busy, busy || out_valid, "accepted beat lost")
  // a result always lands as the sequencer returns to idle
  `SMPQ_ASSERT_NOW(a_result_idle, out_valid, !busy, "result strobe while busy")
  // faults are exclusive and only seen with an empty or full queue
  `SMPQ_ASSERT_NOW(a_flags_excl, out_valid, !(out_underflow && out_overflow), "both faults set")
  `SMPQ_ASSERT_NOW(a_under_empty, out_valid && out_underflow, out_occupancy == '0, "underflow not empty")
  `SMPQ_ASSERT_NOW(a_over_full, out_valid && out_overflow, out_occupancy == OCC_W'(DEPTH), "overflow not full")

endmodule
